// ----- src/cau_pkg.sv -----
// Shared types, constants and saturation helper for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    localparam int DATA_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int REM_W      = DATA_W + 3;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_RSCALE = 3'd2,
        CMD_ISCALE = 3'd3,
        CMD_MUL    = 3'd4,
        CMD_MAG    = 3'd5
    } t_cmd;

    // One square-root lane: finished results ride along with the root state.
    typedef struct packed {
        logic              mag;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              ovf;
        logic [PROD_W-1:0] x;
        logic [REM_W-1:0]  rem;
        logic [DATA_W-1:0] root;
    } t_lane;

    // Clamp to signed 32 bits; the top bit of the result is the overflow flag.
    function automatic logic [DATA_W:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > 65'sd2147483647) begin
            return {1'b1, S32_MAX};
        end else if (v < -65'sd2147483648) begin
            return {1'b1, S32_MIN};
        end
        return {1'b0, v[DATA_W-1:0]};
    endfunction

endpackage
`default_nettype wire

// ----- src/cau_if.sv -----
// Valid/ready channel interfaces for operand beats and result beats.
`default_nettype none
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic signed [31:0] factor;

    modport source (output valid, command, a_re, a_im, b_re, b_im, factor, input ready);
    modport sink   (input valid, command, a_re, a_im, b_re, b_im, factor, output ready);
endinterface

interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic               overflow;

    modport source (output valid, result_re, result_im, overflow, input ready);
    modport sink   (input valid, result_re, result_im, overflow, output ready);
endinterface
`default_nettype wire

// ----- src/cau_sqrt_step.sv -----
// One restoring square-root step: one result bit per register stage.
`default_nettype none
module cau_sqrt_step import cau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    logic             r_valid;
    t_lane            r_lane;
    t_lane            n_lane;
    logic [REM_W-1:0] w_rem;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    always_comb begin
        w_rem   = {i_lane.rem[REM_W-3:0], i_lane.x[PROD_W-1 -: 2]};
        w_trial = {1'b0, i_lane.root, 2'b01};
        w_ge    = (w_rem >= w_trial);
        n_lane      = i_lane;
        n_lane.x    = {i_lane.x[PROD_W-3:0], 2'b00};
        n_lane.rem  = w_ge ? (w_rem - w_trial) : w_rem;
        n_lane.root = {i_lane.root[DATA_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule
`default_nettype wire

// ----- src/complex_arithmetic_unit.sv -----
// Beats pass the operand, product, combine, square-root and output registers in order.
// Throughput: one beat per cycle; add, scale, multiply and magnitude all share one pipe.
// The depth is set by the magnitude square root, one result bit per stage (32 stages).
// A stall on the output freezes the whole pipe; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits; payload registers are not reset.
`default_nettype none
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cau_in_if.sink           i_in,
    cau_out_if.source        o_res
);

    // Global advance: move every stage when the output register is free or drained.
    logic w_en;

    // ---- Stage 1: capture operands ----
    logic               r1_v;
    t_cmd               r1_cmd;
    logic signed [31:0] r1_ar, r1_ai, r1_br, r1_bi, r1_f;

    // ---- Stage 2: four products and the add/subtract ----
    logic                     r2_v;
    t_cmd                     r2_cmd;
    logic signed [PROD_W-1:0] r2_p0, r2_p1, r2_p2, r2_p3;
    logic signed [DATA_W:0]   r2_sre, r2_sim;

    logic signed [31:0]       w_m0y, w_m1y, w_m2x, w_m2y;
    logic signed [PROD_W-1:0] w_p0, w_p1, w_p2, w_p3;
    logic signed [DATA_W:0]   w_sre, w_sim;

    // ---- Stage 3: combine, shift, saturate ----
    logic signed [PROD_W-1:0] w_p0m, w_p1m, w_p3m;
    logic signed [SUM_W-1:0]  w_re_sum, w_im_sum;
    logic [DATA_W:0]          w_re_sat, w_im_sat;
    logic [DATA_W:0]          w_sre_sat, w_sim_sat;
    t_lane                    w_lane0;

    // ---- Square-root lanes ----
    logic  w_v    [0:SQRT_STEPS];
    t_lane w_lane [0:SQRT_STEPS];
    logic  r3_v;
    t_lane r3_lane;

    // ---- Output register ----
    logic              r_ov;
    logic [DATA_W-1:0] r_ore, r_oim;
    logic              r_oovf;
    logic [DATA_W-1:0] n_ore, n_oim;
    logic              n_oovf;

    assign w_en       = !r_ov || o_res.ready;
    assign i_in.ready = w_en;

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd <= t_cmd'(i_in.command);
            r1_ar  <= i_in.a_re;
            r1_ai  <= i_in.a_im;
            r1_br  <= i_in.b_re;
            r1_bi  <= i_in.b_im;
            r1_f   <= i_in.factor;
        end
    end

    // Stage 2: steer so scale, multiply and magnitude map onto (p0 -/+ p1, p2 + p3).
    // Magnitude squares a through the first two multipliers.
    always_comb begin
        w_m0y = (r1_cmd == CMD_MUL) ? r1_br : ((r1_cmd == CMD_MAG) ? r1_ar : r1_f);
        w_m1y = (r1_cmd == CMD_MUL) ? r1_bi : ((r1_cmd == CMD_MAG) ? r1_ai : r1_f);
        w_m2x = (r1_cmd == CMD_RSCALE) ? r1_ai : r1_ar;
        w_m2y = (r1_cmd == CMD_MUL) ? r1_bi : r1_f;
        w_p0  = 64'(r1_ar) * 64'(w_m0y);
        w_p1  = 64'(r1_ai) * 64'(w_m1y);
        w_p2  = 64'(w_m2x) * 64'(w_m2y);
        w_p3  = 64'(r1_ai) * 64'(r1_br);
        if (r1_cmd == CMD_SUB) begin
            w_sre = 33'(r1_ar) - 33'(r1_br);
            w_sim = 33'(r1_ai) - 33'(r1_bi);
        end else begin
            w_sre = 33'(r1_ar) + 33'(r1_br);
            w_sim = 33'(r1_ai) + 33'(r1_bi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cmd <= r1_cmd;
            r2_p0  <= w_p0;
            r2_p1  <= w_p1;
            r2_p2  <= w_p2;
            r2_p3  <= w_p3;
            r2_sre <= w_sre;
            r2_sim <= w_sim;
        end
    end

    // Stage 3: exact sum, one floor shift, then clamp. Imaginary scale gives
    // re = (0 - ai*f) >> F, so the negated factor never has to be formed.
    always_comb begin
        w_p0m    = (r2_cmd == CMD_ISCALE) ? '0 : r2_p0;
        w_p1m    = (r2_cmd == CMD_RSCALE) ? '0 : r2_p1;
        w_p3m    = (r2_cmd == CMD_MUL)    ? r2_p3 : '0;
        w_re_sum = (r2_cmd == CMD_MAG) ? (65'(r2_p0) + 65'(r2_p1))
                                       : (65'(w_p0m) - 65'(w_p1m));
        w_im_sum = 65'(r2_p2) + 65'(w_p3m);
        w_re_sat = sat32(w_re_sum >>> FRAC_BITS);
        w_im_sat = sat32(w_im_sum >>> FRAC_BITS);
        w_sre_sat = sat32(65'(r2_sre));
        w_sim_sat = sat32(65'(r2_sim));

        w_lane0      = '0;
        w_lane0.x    = w_re_sum[PROD_W-1:0];
        case (r2_cmd)
            CMD_ADD, CMD_SUB: begin
                w_lane0.re  = w_sre_sat[DATA_W-1:0];
                w_lane0.im  = w_sim_sat[DATA_W-1:0];
                w_lane0.ovf = w_sre_sat[DATA_W] | w_sim_sat[DATA_W];
            end
            CMD_RSCALE, CMD_ISCALE, CMD_MUL: begin
                w_lane0.re  = w_re_sat[DATA_W-1:0];
                w_lane0.im  = w_im_sat[DATA_W-1:0];
                w_lane0.ovf = w_re_sat[DATA_W] | w_im_sat[DATA_W];
            end
            CMD_MAG: begin
                w_lane0.mag = 1'b1;
            end
            default: begin
                // undefined commands: all zero
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_lane <= w_lane0;
        end
    end

    assign w_v[0]    = r3_v;
    assign w_lane[0] = r3_lane;

    // Square root of the sum of squares, one bit per stage; other results ride along.
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        cau_sqrt_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_v[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    // Output stage: clamp the root to the largest positive value.
    always_comb begin
        if (w_lane[SQRT_STEPS].mag) begin
            n_oim  = '0;
            n_oovf = w_lane[SQRT_STEPS].root[DATA_W-1];
            n_ore  = n_oovf ? S32_MAX : w_lane[SQRT_STEPS].root;
        end else begin
            n_ore  = w_lane[SQRT_STEPS].re;
            n_oim  = w_lane[SQRT_STEPS].im;
            n_oovf = w_lane[SQRT_STEPS].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ore  <= n_ore;
            r_oim  <= n_oim;
            r_oovf <= n_oovf;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.result_re = r_ore;
    assign o_res.result_im = r_oim;
    assign o_res.overflow  = r_oovf;

endmodule
`default_nettype wire

// ----- src/cau_checker.sv -----
// Port-level checks for the complex arithmetic unit, bound to the top level.
`default_nettype none
module cau_checker import cau_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_re,
    input wire logic [31:0] i_im,
    input wire logic        i_ovf
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_re) && $stable(i_im) && $stable(i_ovf))
        else $error("stalled result beat changed");

    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ovf |->
            (i_re == S32_MAX) || (i_re == S32_MIN) || (i_im == S32_MAX) || (i_im == S32_MIN))
        else $error("overflow flagged without a clamped part");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output is empty");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_re        (o_res.result_re),
    .i_im        (o_res.result_im),
    .i_ovf       (o_res.overflow)
);
`default_nettype wire
